// ===== src/circular_nearest_angle_lookup_core_macros.svh =====
// ----------------------------------------------------------------------------
// circular nearest angle lookup: assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_NEAREST_ANGLE_LOOKUP_CORE_MACROS_SVH
`define CIRCULAR_NEAREST_ANGLE_LOOKUP_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define CNAL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cnal assertion failed");

// condition implies consequence in the next cycle
`define CNAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cnal assertion failed");

`endif

// ===== src/cnal_pkg.sv =====
// ----------------------------------------------------------------------------
// cnal_pkg
// Item types, command codes and fold constants for the nearest angle lookup.
// ----------------------------------------------------------------------------
package cnal_pkg;

    // command codes
    localparam logic [1:0] CMD_QUERY      = 2'd0;
    localparam logic [1:0] CMD_WRITE      = 2'd1;
    localparam logic [1:0] CMD_INVALIDATE = 2'd2;

    // circle and fold constants
    localparam int unsigned FULL_CIRCLE = 360;
    // offset that lifts any 16-bit signed angle above zero (92 * 360)
    localparam logic [16:0] FOLD_OFFSET = 17'd33120;
    // reciprocal of 360 scaled by 2^25, rounded up
    localparam logic [16:0] RECIP_360   = 17'd93207;
    localparam int unsigned RECIP_SHIFT = 25;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] query_angle;
        logic [3:0]         slot;
        logic [8:0]         entry_angle;
        logic [15:0]        entry_id;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_id;
        logic [8:0]  match_angle;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;
        logic inv_en;
        logic load_x;
        logic do_mul;
        logic do_sub;
        logic rd_en;
        logic load_out;
    } ctrl_cmd_t;

endpackage

// ===== src/cnal_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnal_ctrl
// Sequencer: takes items, runs fold, table scan and decision, owns m_valid.
// ----------------------------------------------------------------------------
module cnal_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cnal_pkg::ctrl_cmd_t  cmd,
    output logic [IDX_W-1:0]     rd_addr
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_SUB    = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DECIDE = 6'b100000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             out_free;
    logic             scan_last;
    logic             busy;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign rd_addr   = cnt_reg;
    assign scan_last = (state_reg == ST_SCAN) && (cnt_reg == LAST_IDX);
    assign busy      = (state_reg != ST_IDLE);

    // command decode
    always_comb begin
        cmd          = '0;
        cmd.wr_en    = accept && (s_command == cnal_pkg::CMD_WRITE);
        cmd.inv_en   = accept && (s_command == cnal_pkg::CMD_INVALIDATE);
        cmd.load_x   = accept && (s_command == cnal_pkg::CMD_QUERY);
        cmd.do_mul   = (state_reg == ST_MUL);
        cmd.do_sub   = (state_reg == ST_SUB);
        cmd.rd_en    = (state_reg == ST_SCAN);
        cmd.load_out = (state_reg == ST_DECIDE) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (cmd.load_x) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `include "circular_nearest_angle_lookup_core_macros.svh"

    `CNAL_ASSERT_NEXT(a_query_starts_fold, cmd.load_x, state_reg == ST_MUL)
    `CNAL_ASSERT_NEXT(a_scan_ends_in_drain, scan_last, state_reg == ST_DRAIN)
    `CNAL_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, m_valid_reg)
    `CNAL_ASSERT_NEXT(a_decide_waits, (state_reg == ST_DECIDE) && m_valid_reg && !m_ready, state_reg == ST_DECIDE)
    `CNAL_ASSERT_NOW(a_busy_blocks_input, busy, !s_ready && !cmd.wr_en && !cmd.inv_en)

endmodule

// ===== src/cnal_datapath.sv =====
// ----------------------------------------------------------------------------
// cnal_datapath
// Slot table, query fold, scan accumulators, nearest decision and result.
// ----------------------------------------------------------------------------
module cnal_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cnal_pkg::in_item_t   s_item,
    input  cnal_pkg::ctrl_cmd_t  cmd,
    input  logic [IDX_W-1:0]     rd_addr,
    output cnal_pkg::out_item_t  m_item
);

    localparam logic [9:0] CIRCLE = 10'(cnal_pkg::FULL_CIRCLE);

    // table storage
    logic [8:0]               ang_mem [TABLE_ENTRIES];
    logic [15:0]              id_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic             slot_ok;
    logic [IDX_W-1:0] wr_addr;
    logic [8:0]       wr_ang;

    // read port
    logic        rd_vld_reg;
    logic        rd_ent_reg;
    logic [8:0]  rd_ang_reg;
    logic [15:0] rd_id_reg;

    // fold
    logic [16:0] x_reg;
    logic [8:0]  q_reg;
    logic [8:0]  w_reg;
    logic [33:0] prod;
    logic [16:0] q_times;

    // accumulators
    logic        lo_f_reg, hi_f_reg, bl_f_reg, ab_f_reg;
    logic [8:0]  lo_a_reg, hi_a_reg, bl_a_reg, ab_a_reg;
    logic [15:0] lo_i_reg, hi_i_reg, bl_i_reg, ab_i_reg;

    // decision
    logic [8:0]  pa, sa;
    logic [15:0] pid, sid;
    logic [9:0]  pd, sd;

    cnal_pkg::out_item_t out_reg;

    assign slot_ok = ({3'b000, s_item.slot} < 7'(TABLE_ENTRIES));
    assign wr_addr = IDX_W'(s_item.slot);
    assign wr_ang  = (s_item.entry_angle >= 9'(cnal_pkg::FULL_CIRCLE))
                   ? s_item.entry_angle - 9'(cnal_pkg::FULL_CIRCLE)
                   : s_item.entry_angle;

    // table writes and registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && slot_ok) begin
            ang_mem[wr_addr] <= wr_ang;
            id_mem[wr_addr]  <= s_item.entry_id;
        end
        if (cmd.rd_en) begin
            rd_ang_reg <= ang_mem[rd_addr];
            rd_id_reg  <= id_mem[rd_addr];
            rd_ent_reg <= valid_reg[rd_addr];
        end
    end

    // valid bits and read strobe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.wr_en && slot_ok) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.inv_en && slot_ok) begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    // fold query modulo 360 by reciprocal multiply
    assign prod    = 34'(x_reg) * 34'(cnal_pkg::RECIP_360);
    assign q_times = 17'(q_reg) * 17'(cnal_pkg::FULL_CIRCLE);

    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= 17'(s_item.query_angle) + cnal_pkg::FOLD_OFFSET;
        end
        if (cmd.do_mul) begin
            q_reg <= prod[cnal_pkg::RECIP_SHIFT +: 9];
        end
        if (cmd.do_sub) begin
            w_reg <= 9'(x_reg - q_times);
        end
    end

    // scan accumulators, strict compares keep the lowest slot on equal angles
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.do_mul) begin
            lo_f_reg <= 1'b0;
            hi_f_reg <= 1'b0;
            bl_f_reg <= 1'b0;
            ab_f_reg <= 1'b0;
        end else if (rd_vld_reg && rd_ent_reg) begin
            if (!lo_f_reg || (rd_ang_reg < lo_a_reg)) begin
                lo_f_reg <= 1'b1;
                lo_a_reg <= rd_ang_reg;
                lo_i_reg <= rd_id_reg;
            end
            if (!hi_f_reg || (rd_ang_reg > hi_a_reg)) begin
                hi_f_reg <= 1'b1;
                hi_a_reg <= rd_ang_reg;
                hi_i_reg <= rd_id_reg;
            end
            if (rd_ang_reg <= w_reg) begin
                if (!bl_f_reg || (rd_ang_reg > bl_a_reg)) begin
                    bl_f_reg <= 1'b1;
                    bl_a_reg <= rd_ang_reg;
                    bl_i_reg <= rd_id_reg;
                end
            end else begin
                if (!ab_f_reg || (rd_ang_reg < ab_a_reg)) begin
                    ab_f_reg <= 1'b1;
                    ab_a_reg <= rd_ang_reg;
                    ab_i_reg <= rd_id_reg;
                end
            end
        end
    end

    // predecessor and successor with wrap, distances round the circle
    always_comb begin
        pa  = bl_f_reg ? bl_a_reg : hi_a_reg;
        pid = bl_f_reg ? bl_i_reg : hi_i_reg;
        sa  = ab_f_reg ? ab_a_reg : lo_a_reg;
        sid = ab_f_reg ? ab_i_reg : lo_i_reg;
        pd  = (pa <= w_reg) ? (10'(w_reg) - 10'(pa)) : (CIRCLE - 10'(pa) + 10'(w_reg));
        sd  = (sa > w_reg)  ? (10'(sa) - 10'(w_reg)) : (CIRCLE - 10'(w_reg) + 10'(sa));
    end

    // result register, zero when the table is empty
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.found <= lo_f_reg;
            if (!lo_f_reg) begin
                out_reg.match_id    <= '0;
                out_reg.match_angle <= '0;
            end else if (sd < pd) begin
                out_reg.match_id    <= sid;
                out_reg.match_angle <= sa;
            end else begin
                out_reg.match_id    <= pid;
                out_reg.match_angle <= pa;
            end
        end
    end

    assign m_item = out_reg;

endmodule

// ===== src/circular_nearest_angle_lookup_core.sv =====
// ----------------------------------------------------------------------------
// circular_nearest_angle_lookup_core
// Slot table of angles and ids answering nearest-angle queries on a circle.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel takes one item: a query, a slot write or a slot invalidate.
//   Writes and invalidates complete at acceptance and give no result.
//   A query gives exactly one item on the m_ channel: the nearest valid
//   entry (predecessor wins ties), or found low with zeros on an empty table.
//   A query runs from acceptance to m_valid in steps: it folds the angle
//   through a reciprocal multiply and then a subtract, scans the slots in
//   order through the table's single read port, takes the last read, then
//   decides and loads the output register. No item is taken while a query
//   is in flight; the next is taken once its result is loaded. Writes and
//   invalidates keep the block idle, so it stays ready for the next item.
//   Reset (aresetn low, synchronous) empties the table at once and drops any
//   result in flight.
//   A stalled receiver holds the result in the output register; the block
//   still takes new items until its next query reaches the decision, then
//   waits there, taking no items, for the pending one to be taken.
// ----------------------------------------------------------------------------
module circular_nearest_angle_lookup_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cnal_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cnal_pkg::out_item_t m_item
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    cnal_pkg::ctrl_cmd_t cmd;
    logic [IDX_W-1:0]    rd_addr;

    cnal_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_command(s_item.command),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    cnal_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_item (s_item),
        .cmd    (cmd),
        .rd_addr(rd_addr),
        .m_item (m_item)
    );

endmodule

// ===== bench/cnal_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cnal_result_checker
// Watches both channels of the nearest angle lookup, keeps a shadow of the
// slot table, works out the answer to every accepted query and compares it
// field by field with the items that leave the block, in order.
// ----------------------------------------------------------------------------
module cnal_result_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cnal_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cnal_pkg::out_item_t m_item,
    output int                  fail_count,
    output int                  pending_count
);

    localparam int CIRCLE = int'(cnal_pkg::FULL_CIRCLE);

    // shadow of the slot table
    logic [8:0]  shadow_angle [TABLE_ENTRIES];
    logic [15:0] shadow_id    [TABLE_ENTRIES];
    logic        shadow_live  [TABLE_ENTRIES];

    // answers still owed by the block, oldest first
    cnal_pkg::out_item_t owed_answers[$];
    int                  mismatches = 0;
    int                  owed_size  = 0;

    assign fail_count    = mismatches;
    assign pending_count = owed_size;

    // nearest live entry on the circle, predecessor wins ties
    function automatic cnal_pkg::out_item_t nearest_entry(input logic signed [15:0] raw);
        int                  folded;
        int                  floor_slot;
        int                  ceil_slot;
        int                  min_slot;
        int                  max_slot;
        int                  pred_slot;
        int                  succ_slot;
        int                  pred_dist;
        int                  succ_dist;
        int                  chosen;
        int                  a;
        cnal_pkg::out_item_t answer;
        folded     = ((int'(raw) % CIRCLE) + CIRCLE) % CIRCLE;
        floor_slot = -1;
        ceil_slot  = -1;
        min_slot   = -1;
        max_slot   = -1;
        answer     = '0;
        // strict comparisons keep the lowest slot among equal angles
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_live[i]) begin
                a = int'(shadow_angle[i]);
                if (min_slot < 0 || a < int'(shadow_angle[min_slot])) min_slot = i;
                if (max_slot < 0 || a > int'(shadow_angle[max_slot])) max_slot = i;
                if (a <= folded) begin
                    if (floor_slot < 0 || a > int'(shadow_angle[floor_slot])) floor_slot = i;
                end else begin
                    if (ceil_slot < 0 || a < int'(shadow_angle[ceil_slot])) ceil_slot = i;
                end
            end
        end
        if (min_slot < 0) return answer;
        // wrap round the circle when nothing lies on one side
        pred_slot = (floor_slot >= 0) ? floor_slot : max_slot;
        succ_slot = (ceil_slot >= 0) ? ceil_slot : min_slot;
        a = int'(shadow_angle[pred_slot]);
        pred_dist = (a <= folded) ? folded - a : CIRCLE - a + folded;
        a = int'(shadow_angle[succ_slot]);
        succ_dist = (a > folded) ? a - folded : CIRCLE - folded + a;
        chosen = (succ_dist < pred_dist) ? succ_slot : pred_slot;
        answer.found       = 1'b1;
        answer.match_id    = shadow_id[chosen];
        answer.match_angle = shadow_angle[chosen];
        return answer;
    endfunction

    always @(posedge aclk) begin
        cnal_pkg::out_item_t want;
        int                  stored;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                shadow_angle[i] = '0;
                shadow_id[i]    = '0;
                shadow_live[i]  = 1'b0;
            end
            owed_answers.delete();
        end else begin
            // result side: compare with the oldest owed answer
            if (m_valid && m_ready) begin
                if (owed_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with no query outstanding, got %h",
                             $time, m_item);
                end else begin
                    want = owed_answers.pop_front();
                    if (m_item.found !== want.found) begin
                        mismatches++;
                        $display("%0t: found expected %0d got %0d",
                                 $time, want.found, m_item.found);
                    end
                    if (m_item.match_id !== want.match_id) begin
                        mismatches++;
                        $display("%0t: match_id expected %h got %h",
                                 $time, want.match_id, m_item.match_id);
                    end
                    if (m_item.match_angle !== want.match_angle) begin
                        mismatches++;
                        $display("%0t: match_angle expected %0d got %0d",
                                 $time, want.match_angle, m_item.match_angle);
                    end
                end
            end
            // input side: update the shadow table or queue an answer
            if (s_valid && s_ready) begin
                case (s_item.command)
                    cnal_pkg::CMD_QUERY: begin
                        owed_answers.push_back(nearest_entry(s_item.query_angle));
                    end
                    cnal_pkg::CMD_WRITE: begin
                        if (int'(s_item.slot) < TABLE_ENTRIES) begin
                            stored = int'(s_item.entry_angle);
                            if (stored >= CIRCLE) stored -= CIRCLE;
                            shadow_angle[s_item.slot] = 9'(stored);
                            shadow_id[s_item.slot]    = s_item.entry_id;
                            shadow_live[s_item.slot]  = 1'b1;
                        end
                    end
                    cnal_pkg::CMD_INVALIDATE: begin
                        if (int'(s_item.slot) < TABLE_ENTRIES) begin
                            shadow_live[s_item.slot] = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        owed_size <= owed_answers.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the nearest angle lookup with a directed opening (empty table,
// wrap on both sides, ties, duplicate angles, out of range angles, the
// unused command) followed by random writes, invalidates and queries with
// varying table fill, random idling on both channels and one long receiver
// hold-off. Checking is done by the result checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          HOLD_CYCLES  = 400;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cnal_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cnal_pkg::out_item_t m_item;
    int                  errors;
    int                  pending;
    bit                  hold_request = 1'b0;
    bit                  calm_tx = 1'b0;
    int unsigned         cycle_count = 0;

    circular_nearest_angle_lookup_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    cnal_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (errors),
        .pending_count (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_length(input bit calm);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (calm || p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cnal_pkg::in_item_t make_item(input logic [1:0] cmd, input int q,
                                                     input int slot, input int ang,
                                                     input int id);
        cnal_pkg::in_item_t it;
        it.command     = cmd;
        it.query_angle = 16'(q);
        it.slot        = 4'(slot);
        it.entry_angle = 9'(ang);
        it.entry_id    = 16'(id);
        return it;
    endfunction

    // random item; fill_bias is the chance in percent that a table update is a write
    function automatic cnal_pkg::in_item_t random_item(input int unsigned fill_bias);
        cnal_pkg::in_item_t it;
        int unsigned        p;
        it.command     = cnal_pkg::CMD_QUERY;
        it.query_angle = 16'($urandom);
        it.slot        = 4'($urandom);
        it.entry_angle = 9'($urandom_range(0, 359));
        it.entry_id    = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 50) begin
            // full range, near the circle, or close to a coarse grid of angles
            p = $urandom_range(0, 99);
            if (p >= 50 && p < 80) begin
                it.query_angle = 16'(int'($urandom_range(0, 1440)) - 720);
            end else if (p >= 80) begin
                it.query_angle = 16'(45 * int'($urandom_range(0, 7))
                                     + int'($urandom_range(0, 4)) - 2
                                     + 360 * (int'($urandom_range(0, 180)) - 90));
            end
        end else if (p < 97) begin
            it.command = ($urandom_range(0, 99) < fill_bias) ? cnal_pkg::CMD_WRITE
                                                              : cnal_pkg::CMD_INVALIDATE;
            // out of range angles and a coarse grid for duplicates and ties
            p = $urandom_range(0, 99);
            if (p < 15) it.entry_angle = 9'($urandom_range(360, 511));
            else if (p < 30) it.entry_angle = 9'(45 * $urandom_range(0, 7));
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // offer one item and hold it until it is taken, then maybe go idle
    task automatic send(input cnal_pkg::in_item_t it);
        int unsigned gap;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        gap = idle_length(calm_tx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int unsigned run;
        int unsigned stall;
        bit          calm_rx;
        calm_rx = 1'b0;
        repeat (8) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                run = $urandom_range(1, 24);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                if ($urandom_range(0, 15) == 0) calm_rx = ($urandom_range(0, 2) == 0);
                stall = idle_length(calm_rx);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // reset, stimulus and verdict
    initial begin : stimulus
        cnal_pkg::in_item_t it;
        int                 sent;
        int unsigned        fill_bias;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening
        send(make_item(cnal_pkg::CMD_QUERY, -32768, 0, 0, 0));          // empty table
        send(make_item(cnal_pkg::CMD_WRITE, 0, 0, 0, 16'hFFFF));
        send(make_item(cnal_pkg::CMD_WRITE, 0, 15, 511, 16'h0000));     // stored as 151
        send(make_item(cnal_pkg::CMD_WRITE, 0, 7, 359, 16'h1234));
        send(make_item(cnal_pkg::CMD_WRITE, 0, 3, 180, 16'hABCD));
        send(make_item(cnal_pkg::CMD_QUERY, 32767, 0, 0, 0));           // folds to 7
        send(make_item(cnal_pkg::CMD_QUERY, -1, 0, 0, 0));              // folds to 359
        send(make_item(cnal_pkg::CMD_QUERY, 90, 0, 0, 0));
        send(make_item(cnal_pkg::CMD_WRITE, 0, 4, 200, 16'h4444));
        send(make_item(cnal_pkg::CMD_QUERY, 190, 0, 0, 0));             // tie, predecessor
        send(make_item(cnal_pkg::CMD_WRITE, 0, 9, 180, 16'h5555));      // duplicate angle
        send(make_item(cnal_pkg::CMD_QUERY, 180, 0, 0, 0));
        send(make_item(CMD_UNUSED, -1, 15, 511, 16'hFFFF));             // ignored
        send(make_item(cnal_pkg::CMD_INVALIDATE, 0, 3, 0, 0));
        send(make_item(cnal_pkg::CMD_QUERY, 181, 0, 0, 0));
        send(make_item(cnal_pkg::CMD_WRITE, 0, 5, 360, 16'h8001));      // stored as 0
        send(make_item(cnal_pkg::CMD_QUERY, 0, 0, 0, 0));
        send(make_item(cnal_pkg::CMD_INVALIDATE, 0, 0, 0, 0));
        send(make_item(cnal_pkg::CMD_QUERY, 2, 0, 0, 0));
        send(make_item(cnal_pkg::CMD_QUERY, -32768, 0, 0, 0));          // folds to 352
        send(make_item(cnal_pkg::CMD_INVALIDATE, 0, 5, 0, 0));
        send(make_item(cnal_pkg::CMD_QUERY, 5, 0, 0, 0));               // wraps below zero

        // back to back queries against a held receiver
        hold_request = 1'b1;
        calm_tx = 1'b1;
        for (int k = 0; k < 40; k++) begin
            it = random_item(100);
            it.command = cnal_pkg::CMD_QUERY;
            send(it);
        end
        calm_tx = 1'b0;

        // random part, table fill drifting between empty and full
        sent = 0;
        fill_bias = 60;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: fill_bias = 10;
                    1: fill_bias = 50;
                    2: fill_bias = 85;
                    default: fill_bias = 100;
                endcase
            end
            if (sent % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
            it = random_item(fill_bias);
            send(it);
            if (it.command != CMD_UNUSED) sent++;
        end
        s_valid <= 1'b0;

        // drain and let the block settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== circular_nearest_angle_lookup_core.f =====
+incdir+src
src/cnal_pkg.sv
src/cnal_ctrl.sv
src/cnal_datapath.sv
src/circular_nearest_angle_lookup_core.sv
bench/cnal_result_checker.sv
bench/testbench.sv
